FILE: design/primary_ray_direction_generator_core_defines.svh
// Assertion macros shared by the ray direction generator.
`ifndef PRIMARY_RAY_DIRECTION_GENERATOR_CORE_DEFINES_SVH
`define PRIMARY_RAY_DIRECTION_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRDG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PRDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/prdg_pkg.sv
// ----------------------------------------------------------------------------
// prdg_pkg
// Shared constants and types of the primary ray direction generator.
// ----------------------------------------------------------------------------
package prdg_pkg;

  // Pixel coordinate width and stream payload widths.
  localparam int COORD_BITS = 12;
  localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = 48;
  localparam int PROD_W     = COORD_BITS + 32;

  // Configuration port.
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // Arithmetic widths.
  localparam int OFS_W  = 48;
  localparam int MAG_W  = 63;
  localparam int NRM_W  = 30;
  localparam int SQ_W   = 60;
  localparam int RAD_W  = 62;
  localparam int ROOT_W = 31;
  localparam int REM_W  = 33;
  localparam int NUM_W  = 45;
  localparam int Q_W    = 15;

  // Pipeline depths.
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = Q_W;
  localparam int LAT         = 10 + SQRT_STAGES + 1 + DIV_STAGES + 1;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_FORWARD     = 3'd0,
    REG_RIGHT       = 3'd1,
    REG_UP          = 3'd2,
    REG_HALF_WIDTH  = 3'd3,
    REG_HALF_HEIGHT = 3'd4,
    REG_PIXEL_PITCH = 3'd5
  } cfg_reg_e;

  typedef logic [NRM_W-1:0] nrm_t;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    nrm_t [2:0]       mag;
  } sqrt_side_t;

  // Data that rides alongside the dividers.
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } div_side_t;

  // Signed Q1.14 component k of a packed vector.
  function automatic logic signed [15:0] vec_comp(input logic [47:0] v, input int k);
    logic [15:0] r;
    r = v[16*k +: 16];
    return $signed(r);
  endfunction

endpackage

FILE: design/primary_ray_direction_generator_core.sv
// ----------------------------------------------------------------------------
// primary_ray_direction_generator_core
// Pinhole camera primary ray direction: pixel coordinates in, unit vector out.
// ----------------------------------------------------------------------------
// Channel     Direction  Payload
// s_axis      in         pixel_x, pixel_y
// m_axis      out        dir_x, dir_y, dir_z (signed Q1.14)
// apb         in/out     camera basis and image plane scalars
//
// One ray is accepted per clock while no result is held at the output. The
// datapath has 58 register stages: ten for offsets, products, normalization
// and squares, the 31-stage square root, one numerator stage, the 15-stage
// dividers and the output register.
// Reset clears the valid bits and loads the default camera configuration.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "primary_ray_direction_generator_core_defines.svh"

module primary_ray_direction_generator_core import prdg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream, tdata: pixel_x, pixel_y.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  // Output stream, tdata: dir_x, dir_y, dir_z.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers.
  logic [47:0] fwd_q, right_q, up_q;
  logic [31:0] half_w_q, half_h_q, pitch_q;
  cfg_reg_e    cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q    <= 48'h4000_0000_0000;
      right_q  <= 48'h0000_0000_4000;
      up_q     <= 48'h0000_4000_0000;
      half_w_q <= 32'h0100_0000;
      half_h_q <= 32'h0100_0000;
      pitch_q  <= 32'd52429;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FORWARD:     fwd_q    <= pwdata[47:0];
        REG_RIGHT:       right_q  <= pwdata[47:0];
        REG_UP:          up_q     <= pwdata[47:0];
        REG_HALF_WIDTH:  half_w_q <= pwdata[31:0];
        REG_HALF_HEIGHT: half_h_q <= pwdata[31:0];
        REG_PIXEL_PITCH: pitch_q  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_FORWARD:     prdata = {16'd0, fwd_q};
      REG_RIGHT:       prdata = {16'd0, right_q};
      REG_UP:          prdata = {16'd0, up_q};
      REG_HALF_WIDTH:  prdata = {32'd0, half_w_q};
      REG_HALF_HEIGHT: prdata = {32'd0, half_h_q};
      REG_PIXEL_PITCH: prdata = {32'd0, pitch_q};
      default:         prdata = '0;
    endcase
  end

  // Pipeline control: every stage advances unless the result is held.
  logic           en;
  logic           in_acc;
  logic [LAT-1:0] valid_q;

  assign en            = !valid_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid & en;
  assign m_axis_tvalid = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_acc};
    end
  end

  // Stage 1: coordinate times pixel pitch.
  logic [PROD_W-1:0] prx_q, pry_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      prx_q <= PROD_W'(s_axis_tdata[COORD_BITS-1:0]) * PROD_W'(pitch_q);
      pry_q <= PROD_W'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]) * PROD_W'(pitch_q);
    end
  end

  // Stage 2: image plane offsets, saturated.
  localparam logic signed [63:0] OfsLim = 64'sd1 <<< 46;
  logic signed [OFS_W-1:0] w_q, h_q;
  logic signed [63:0]      w_raw, h_raw, w_sat, h_sat;
  always_comb begin
    w_raw = $signed({{(64-PROD_W){1'b0}}, prx_q}) - $signed({32'd0, half_w_q});
    h_raw = $signed({32'd0, half_h_q}) - $signed({{(64-PROD_W){1'b0}}, pry_q});
    w_sat = (w_raw > OfsLim) ? OfsLim : ((w_raw < -OfsLim) ? -OfsLim : w_raw);
    h_sat = (h_raw > OfsLim) ? OfsLim : ((h_raw < -OfsLim) ? -OfsLim : h_raw);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= w_sat[OFS_W-1:0];
      h_q <= h_sat[OFS_W-1:0];
    end
  end

  // Stage 3: offsets times basis components.
  logic signed [63:0] pr_q [3];
  logic signed [63:0] pu_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= 64'(w_q) * 64'(vec_comp(right_q, k));
        pu_q[k] <= 64'(h_q) * 64'(vec_comp(up_q, k));
      end
    end
  end

  // Stage 4: direction components with 38 fraction bits.
  logic signed [63:0] d_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= (64'(vec_comp(fwd_q, k)) <<< 24) + pr_q[k] + pu_q[k];
      end
    end
  end

  // Stage 5: sign and magnitude; the OR of magnitudes has the max's leading one.
  logic [MAG_W-1:0] mag5_q [3];
  logic [2:0]       neg5_q;
  logic [MAG_W-1:0] or5_q;
  logic [MAG_W-1:0] mag5_d [3];
  logic [MAG_W-1:0] or5_d;
  always_comb begin
    logic [63:0] a;
    logic [MAG_W-1:0] m [3];
    for (int k = 0; k < 3; k++) begin
      a    = d_q[k][63] ? (64'd0 - 64'(d_q[k])) : 64'(d_q[k]);
      m[k] = a[MAG_W-1:0];
    end
    or5_d = m[0] | m[1] | m[2];
    for (int k = 0; k < 3; k++) mag5_d[k] = m[k];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag5_q[k] <= mag5_d[k];
        neg5_q[k] <= d_q[k][63];
      end
      or5_q <= or5_d;
    end
  end

  // Stage 6: highest nonzero byte of the OR word.
  logic [MAG_W-1:0] mag6_q [3];
  logic [2:0]       neg6_q;
  logic [2:0]       grp6_q, grp6_d;
  logic [7:0]       byte6_q, byte6_d;
  logic             any6_q, any6_d;
  always_comb begin
    logic [63:0] wd;
    wd      = {1'b0, or5_q};
    grp6_d  = '0;
    byte6_d = '0;
    any6_d  = 1'b0;
    for (int g = 0; g < 8; g++) begin
      if (wd[8*g +: 8] != 8'd0) begin
        grp6_d  = 3'(g);
        byte6_d = wd[8*g +: 8];
        any6_d  = 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag6_q  <= mag5_q;
      neg6_q  <= neg5_q;
      grp6_q  <= grp6_d;
      byte6_q <= byte6_d;
      any6_q  <= any6_d;
    end
  end

  // Stage 7: leading one position within the byte.
  logic [MAG_W-1:0] mag7_q [3];
  logic [2:0]       neg7_q;
  logic [5:0]       pos7_q;
  logic [2:0]       bit7_d;
  logic             zero7_q;
  always_comb begin
    bit7_d = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte6_q[b]) bit7_d = 3'(b);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag7_q  <= mag6_q;
      neg7_q  <= neg6_q;
      pos7_q  <= {grp6_q, bit7_d};
      zero7_q <= !any6_q;
    end
  end

  // Stage 8: common shift that puts the largest magnitude in [2^29, 2^30).
  localparam logic [5:0] NormPos = 6'd29;
  nrm_t [2:0] nrm8_q, nrm8_d;
  logic [2:0] neg8_q;
  logic       zero8_q;
  always_comb begin
    logic [MAG_W-1:0] rs, ls;
    for (int k = 0; k < 3; k++) begin
      rs = mag7_q[k] >> (pos7_q - NormPos);
      ls = mag7_q[k] << (NormPos - pos7_q);
      nrm8_d[k] = (pos7_q >= NormPos) ? rs[NRM_W-1:0] : ls[NRM_W-1:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm8_q  <= nrm8_d;
      neg8_q  <= neg7_q;
      zero8_q <= zero7_q;
    end
  end

  // Stage 9: squares.
  logic [SQ_W-1:0] sq9_q [3];
  sqrt_side_t      side9_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq9_q[k] <= SQ_W'(nrm8_q[k]) * SQ_W'(nrm8_q[k]);
      end
      side9_q <= '{zero: zero8_q, neg: neg8_q, mag: nrm8_q};
    end
  end

  // Stage 10: sum of squares.
  logic [RAD_W-1:0] sum10_q;
  sqrt_side_t       side10_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum10_q  <= RAD_W'(sq9_q[0]) + RAD_W'(sq9_q[1]) + RAD_W'(sq9_q[2]);
      side10_q <= side9_q;
    end
  end

  // Square root stages, with the side data delayed to match.
  logic [ROOT_W-1:0] len;
  sqrt_side_t        sside_q [SQRT_STAGES];

  prdg_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum10_q),
    .root_o (len)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sside_q[0] <= side10_q;
      for (int j = 1; j < SQRT_STAGES; j++) sside_q[j] <= sside_q[j-1];
    end
  end

  // Numerator setup: magnitude * 2^14 plus half the length, for rounding.
  logic [NUM_W-1:0]  num_q [3];
  logic [ROOT_W-1:0] den_q;
  div_side_t         dside_in_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= (NUM_W'(sside_q[SQRT_STAGES-1].mag[k]) << 14) + NUM_W'(len >> 1);
      end
      den_q      <= len;
      dside_in_q <= '{zero: sside_q[SQRT_STAGES-1].zero, neg: sside_q[SQRT_STAGES-1].neg};
    end
  end

  // Three divider lanes.
  logic [Q_W-1:0] quo [3];
  div_side_t      dside_q [DIV_STAGES];

  for (genvar k = 0; k < 3; k++) begin : g_div
    prdg_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[k]),
      .den_i (den_q),
      .quo_o (quo[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0] <= dside_in_q;
      for (int j = 1; j < DIV_STAGES; j++) dside_q[j] <= dside_q[j-1];
    end
  end

  // Output stage: cap at one, restore the sign, zero a degenerate direction.
  localparam logic [15:0] UnitQ14 = 16'd16384;
  logic [15:0] dir_q [3];
  logic [15:0] dir_d [3];
  always_comb begin
    logic [15:0] q;
    for (int k = 0; k < 3; k++) begin
      q = 16'(quo[k]);
      if (q > UnitQ14) q = UnitQ14;
      if (dside_q[DIV_STAGES-1].zero) begin
        dir_d[k] = '0;
      end else begin
        dir_d[k] = dside_q[DIV_STAGES-1].neg[k] ? (16'd0 - q) : q;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) dir_q[k] <= dir_d[k];
    end
  end

  assign m_axis_tdata = {dir_q[2], dir_q[1], dir_q[0]};

  // Checks.
  `PRDG_ASSERT_NOW(a_ready_follows_out, 1'b1,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready does not follow output")
  `PRDG_ASSERT_NOW(a_dir_range, m_axis_tvalid,
    ($signed(dir_q[0]) <= 16'sd16384) && ($signed(dir_q[0]) >= -16'sd16384) &&
    ($signed(dir_q[1]) <= 16'sd16384) && ($signed(dir_q[1]) >= -16'sd16384) &&
    ($signed(dir_q[2]) <= 16'sd16384) && ($signed(dir_q[2]) >= -16'sd16384),
    "direction component beyond unit")
  `PRDG_ASSERT_NEXT(a_stall_freezes, !en, $stable(valid_q), "pipeline moved while stalled")

endmodule

FILE: design/prdg_sqrt.sv
// ----------------------------------------------------------------------------
// prdg_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module prdg_sqrt import prdg_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];

  logic [REM_W-1:0]  rem_in  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_in [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_in  [SQRT_STAGES];

  logic [REM_W-1:0]  rem_d  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_d [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_d  [SQRT_STAGES];

  // Each stage starts from the one before it; the first from the radicand.
  always_comb begin
    for (int j = 0; j < SQRT_STAGES; j++) begin
      if (j == 0) begin
        rem_in[j]  = '0;
        root_in[j] = '0;
        rad_in[j]  = rad_i;
      end else begin
        rem_in[j]  = rem_q[j-1];
        root_in[j] = root_q[j-1];
        rad_in[j]  = rad_q[j-1];
      end
    end
  end

  // One restoring step: bring down two radicand bits and try root*4+1.
  always_comb begin
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;
    for (int j = 0; j < SQRT_STAGES; j++) begin
      rem2      = {rem_in[j], rad_in[j][RAD_W-1 -: 2]};
      trial     = {2'b00, root_in[j], 2'b01};
      diff      = rem2 - trial;
      ge        = (rem2 >= trial);
      rem_d[j]  = ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
      root_d[j] = {root_in[j][ROOT_W-2:0], ge};
      rad_d[j]  = {rad_in[j][RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < SQRT_STAGES; j++) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
        rad_q[j]  <= rad_d[j];
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

FILE: design/prdg_div.sv
// ----------------------------------------------------------------------------
// prdg_div
// Pipelined restoring divider lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prdg_div import prdg_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [Q_W-1:0]    quo_o
);

  logic [ROOT_W-1:0] rem_q [DIV_STAGES];
  logic [Q_W-1:0]    low_q [DIV_STAGES];
  logic [ROOT_W-1:0] den_q [DIV_STAGES];
  logic [Q_W-1:0]    quo_q [DIV_STAGES];

  logic [ROOT_W-1:0] rem_in [DIV_STAGES];
  logic [Q_W-1:0]    low_in [DIV_STAGES];
  logic [ROOT_W-1:0] den_in [DIV_STAGES];
  logic [Q_W-1:0]    quo_in [DIV_STAGES];

  logic [ROOT_W-1:0] rem_d [DIV_STAGES];
  logic [Q_W-1:0]    low_d [DIV_STAGES];
  logic [Q_W-1:0]    quo_d [DIV_STAGES];

  // The upper numerator bits lie below the divisor, so they seed the remainder.
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (j == 0) begin
        rem_in[j] = {1'b0, num_i[NUM_W-1:Q_W]};
        low_in[j] = num_i[Q_W-1:0];
        den_in[j] = den_i;
        quo_in[j] = '0;
      end else begin
        rem_in[j] = rem_q[j-1];
        low_in[j] = low_q[j-1];
        den_in[j] = den_q[j-1];
        quo_in[j] = quo_q[j-1];
      end
    end
  end

  // Shift in one numerator bit and subtract the divisor where it fits.
  always_comb begin
    logic [ROOT_W:0] r2;
    logic [ROOT_W:0] diff;
    logic            ge;
    for (int j = 0; j < DIV_STAGES; j++) begin
      r2       = {rem_in[j], low_in[j][Q_W-1]};
      diff     = r2 - {1'b0, den_in[j]};
      ge       = (r2 >= {1'b0, den_in[j]});
      rem_d[j] = ge ? diff[ROOT_W-1:0] : r2[ROOT_W-1:0];
      low_d[j] = {low_in[j][Q_W-2:0], 1'b0};
      quo_d[j] = {quo_in[j][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        rem_q[j] <= rem_d[j];
        low_q[j] <= low_d[j];
        den_q[j] <= den_in[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the primary ray direction generator: pixel
// coordinates are streamed in under random stalls, every direction that
// comes out is compared with a fixed-point prediction of the camera ray.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import prdg_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int RAND_PHASES  = 6;
  localparam int RAND_PER_PH  = 255;
  localparam int MAX_REPORTS  = 10;
  // Address one past the last register; writes there must be ignored.
  localparam int REG_UNUSED   = 6;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  primary_ray_direction_generator_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Camera configuration as the block should hold it.
  logic [63:0] cam_reg [6];

  // Pixels waiting to be sent and directions waiting to arrive.
  logic [IN_W-1:0]  pixel_q [$];
  logic [OUT_W-1:0] dir_q [$];

  bit pix_fire;
  bit steady;
  bit hold_req;
  int hold_left;
  int gap_left;
  int idle_cycles;
  int mismatches;
  int rays_in;
  int rays_out;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint comp16(input logic [63:0] v, input int k);
    logic signed [15:0] c;
    c = v[16*k +: 16];
    return c;
  endfunction

  // Expected unit direction for one pixel under the current camera.
  function automatic logic [OUT_W-1:0] ray_direction(input logic [11:0] px,
                                                     input logic [11:0] py);
    longint w, h, d, lim;
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned mx, sum, len, q, b, n;
    logic [OUT_W-1:0] r;
    lim = 64'sd1 <<< 46;
    w = $signed({52'b0, px}) * $signed(cam_reg[REG_PIXEL_PITCH])
        - $signed(cam_reg[REG_HALF_WIDTH]);
    h = $signed(cam_reg[REG_HALF_HEIGHT])
        - $signed({52'b0, py}) * $signed(cam_reg[REG_PIXEL_PITCH]);
    if (w > lim) w = lim;
    if (w < -lim) w = -lim;
    if (h > lim) h = lim;
    if (h < -lim) h = -lim;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      d = comp16(cam_reg[REG_FORWARD], k) * (64'sd1 <<< 24)
          + w * comp16(cam_reg[REG_RIGHT], k) + h * comp16(cam_reg[REG_UP], k);
      neg[k] = d < 0;
      mag[k] = neg[k] ? -d : d;
      if (mag[k] > mx) mx = mag[k];
    end
    // A degenerate basis can cancel every component.
    if (mx == 0) return '0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    // Integer square root, two bits at a time.
    n = sum;
    len = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= len + b) begin
        n = n - (len + b);
        len = (len >> 1) + b;
      end else begin
        len = len >> 1;
      end
      b = b >> 2;
    end
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 14) + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      r[16*k +: 16] = neg[k] ? -q[15:0] : q[15:0];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input side: a transaction is taken from the queue once the previous one
  // has been accepted.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || pix_fire)) begin
      pix_fire = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        s_axis_tdata <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        gap_left = steady ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side back-pressure, including one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady ? 1'b1 : (pick_gap() == 0);
      end
    end
  end

  // Accepted pixels become expected directions; results are checked in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pix_fire = 1'b1;
        rays_in++;
        dir_q.push_back(ray_direction(s_axis_tdata[11:0], s_axis_tdata[23:12]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        rays_out++;
        if (dir_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected direction %h", m_axis_tdata);
        end else begin
          logic [OUT_W-1:0] want;
          want = dir_q.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (m_axis_tdata[16*k +: 16] !== want[16*k +: 16]) begin
              mismatches++;
              if (mismatches <= MAX_REPORTS)
                $display("ray %0d dir component %0d: expected %0d, got %0d",
                         rays_out, k, $signed(want[16*k +: 16]),
                         $signed(m_axis_tdata[16*k +: 16]));
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither stream moves.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d directions outstanding", dir_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic cam_write(input int idx, input logic [63:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_AW'(idx * 8);
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= REG_UP) cam_reg[idx] = v & 64'hFFFF_FFFF_FFFF;
    else if (idx <= REG_PIXEL_PITCH) cam_reg[idx] = v & 64'hFFFF_FFFF;
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || s_axis_tvalid || dir_q.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_pixel(input int x, input int y);
    pixel_q.push_back({y[11:0], x[11:0]});
  endtask

  function automatic logic [63:0] axis_unit(input int a, input bit s);
    logic [63:0] v;
    v = '0;
    v[16*a +: 16] = s ? -16'sd16384 : 16'sd16384;
    return v;
  endfunction

  // Random camera: a signed axis-aligned basis, a scaled one, or raw noise.
  task automatic random_camera();
    int mode, a;
    mode = $urandom_range(0, 2);
    a = $urandom_range(0, 2);
    if (mode == 0) begin
      cam_write(REG_FORWARD, axis_unit(a, $urandom_range(0, 1)));
      cam_write(REG_RIGHT, axis_unit((a + 1) % 3, $urandom_range(0, 1)));
      cam_write(REG_UP, axis_unit((a + 2) % 3, $urandom_range(0, 1)));
    end else if (mode == 1) begin
      cam_write(REG_FORWARD, {$urandom(), $urandom()} & 64'h3FFF_3FFF_3FFF);
      cam_write(REG_RIGHT, {$urandom(), $urandom()} & 64'h1FFF_1FFF_1FFF);
      cam_write(REG_UP, {$urandom(), $urandom()} & 64'hC0FF_C0FF_C0FF);
    end else begin
      cam_write(REG_FORWARD, {$urandom(), $urandom()});
      cam_write(REG_RIGHT, {$urandom(), $urandom()});
      cam_write(REG_UP, {$urandom(), $urandom()});
    end
    cam_write(REG_HALF_WIDTH, mode == 2 ? $urandom() : $urandom_range(1 << 20, 1 << 27));
    cam_write(REG_HALF_HEIGHT, mode == 2 ? $urandom() : $urandom_range(1 << 20, 1 << 27));
    cam_write(REG_PIXEL_PITCH, mode == 2 ? $urandom() : $urandom_range(1, 1 << 17));
  endtask

  initial begin
    cam_reg[REG_FORWARD]     = 64'h0000_4000_0000_0000 >> 16;
    cam_reg[REG_FORWARD]     = 64'd70368744177664;
    cam_reg[REG_RIGHT]       = 64'd16384;
    cam_reg[REG_UP]          = 64'd1073741824;
    cam_reg[REG_HALF_WIDTH]  = 64'd16777216;
    cam_reg[REG_HALF_HEIGHT] = 64'd16777216;
    cam_reg[REG_PIXEL_PITCH] = 64'd52429;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default camera: corners, center and one interior pixel.
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(0, 4095);
    push_pixel(4095, 0);
    push_pixel(320, 320);
    push_pixel(2048, 1);
    drain();

    // All-zero basis gives a zero direction; a write past the last
    // register must leave the camera untouched.
    for (int i = REG_FORWARD; i <= REG_PIXEL_PITCH; i++) cam_write(i, '0);
    cam_write(REG_UNUSED, '1);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    drain();

    // Every register at its maximum: non-unit basis, largest offsets.
    for (int i = REG_FORWARD; i <= REG_PIXEL_PITCH; i++) cam_write(i, '1);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(4095, 0);
    drain();

    // Extreme components of mixed sign with the largest pitch.
    cam_write(REG_FORWARD, 64'h8000_7FFF_8000);
    cam_write(REG_RIGHT, 64'h7FFF_8000_0001);
    cam_write(REG_UP, 64'hFFFF_0000_7FFF);
    cam_write(REG_HALF_WIDTH, 64'd0);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(1, 2);
    drain();

    // Random phases: one without idling, one with a long output hold-off.
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_camera();
      steady = (p == 0);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < RAND_PER_PH; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_pixel($urandom_range(0, 1) * 4095, $urandom_range(0, 1) * 4095);
        else
          push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      drain();
    end
    steady = 1'b0;

    repeat (LAT + 20) @(posedge clk_i);
    $display("Sent %0d pixels over %0d camera settings, checked %0d ray directions.",
             rays_in, RAND_PHASES + 4, rays_out);
    $display("%0d mismatches found.", mismatches);
    if (mismatches == 0 && dir_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
